@@ design/total_order_multi_index_rank_core_assert.svh @@
// Assertion macros used by the rank core controller.
// In synthesis builds every macro expands to nothing.
`ifndef TOTAL_ORDER_MULTI_INDEX_RANK_CORE_ASSERT_SVH
`define TOTAL_ORDER_MULTI_INDEX_RANK_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define TOMIR_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("rank core assertion failed");
`define TOMIR_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("rank core forbidden condition seen");
`else
`define TOMIR_ASSERT(lbl, clk, rst_n, prop)
`define TOMIR_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

@@ design/tomir_pkg.sv @@
`timescale 1ns / 1ps

package tomir_pkg;

    localparam int MAX_DIMS   = 8;
    localparam int ORDER_BITS = 4;
    localparam int DIM_W      = $clog2(MAX_DIMS);
    localparam int ORDERS_W   = MAX_DIMS * ORDER_BITS;
    localparam int RANK_W     = 20;
    localparam int COUNT_W    = 19;
    localparam int CFG_W      = 4;
    localparam int SUM_W      = 7;
    localparam int TAB_DEPTH  = 256;

    typedef logic [MAX_DIMS-1:0][ORDER_BITS-1:0] orders_t;
    typedef logic [TAB_DEPTH-1:0][COUNT_W-1:0] binom_tab_t;

    typedef enum logic
    {
        CFG_NUM_DIMS  = 1'b0,
        CFG_MAX_ORDER = 1'b1
    } cfg_index_t;

    typedef enum logic
    {
        OP_TO_MULTI = 1'b0,
        OP_TO_INDEX = 1'b1
    } op_t;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } state_t;

    typedef struct packed
    {
        logic                operation;
        logic [RANK_W-1:0]   term_index;
        logic [ORDERS_W-1:0] orders_in;
    } in_item_t;

    typedef struct packed
    {
        logic [ORDERS_W-1:0] orders_out;
        logic [RANK_W-1:0]   rank_out;
        logic                found;
        logic [COUNT_W-1:0]  term_count;
    } out_item_t;

    typedef struct packed
    {
        logic load;
        logic step;
    } ctrl_cmd_t;

    typedef struct packed
    {
        logic finish;
    } dp_status_t;

    // Entry {d, s} holds C(d+s, d), built with Pascal's rule at elaboration.
    function automatic binom_tab_t build_binom();
        binom_tab_t t;
        t = '0;
        for (int d = 0; d <= MAX_DIMS; d++)
        begin
            for (int s = 0; s < 16; s++)
            begin
                if (d == 0 || s == 0)
                    t[d*16+s] = COUNT_W'(1);
                else
                    t[d*16+s] = t[(d-1)*16+s] + t[d*16+s-1];
            end
        end
        return t;
    endfunction

    localparam binom_tab_t BINOM = build_binom();

    function automatic logic [COUNT_W-1:0] binom(input logic [3:0] d, input logic [3:0] s);
        return BINOM[{d, s}];
    endfunction

endpackage

@@ design/tomir_ctrl.sv @@
`timescale 1ns / 1ps
`include "total_order_multi_index_rank_core_assert.svh"

module tomir_ctrl
    import tomir_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd,
    output logic       busy,
    output logic       done
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                    state_next = ST_RUN;
            end
            ST_RUN:
            begin
                if (status.finish)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd.load = 1'b0;
        cmd.step = 1'b0;
        busy     = 1'b1;
        done     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.load = start;
                busy     = 1'b0;
            end
            ST_RUN:
            begin
                cmd.step = 1'b1;
            end
            ST_DONE:
            begin
                done = 1'b1;
            end
            default:
            begin
                busy = 1'b0;
            end
        endcase
    end

    // Each accepted request yields exactly one result strobe, after a run phase.
    `TOMIR_ASSERT(a_done_single, clk, rst_n, done |=> !done)
    `TOMIR_ASSERT(a_accept_runs, clk, rst_n, (start && !busy) |=> (busy && !done))
    `TOMIR_ASSERT(a_done_after_busy, clk, rst_n, done |-> $past(busy))
    `TOMIR_NEVER(a_load_step_excl, clk, rst_n, cmd.load && cmd.step)

endmodule

@@ design/tomir_dp.sv @@
`timescale 1ns / 1ps

module tomir_dp
    import tomir_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  ctrl_cmd_t        cmd,
    input  in_item_t         req,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    output dp_status_t       status,
    output out_item_t        rsp
);

    logic [CFG_W-1:0]      num_dims_reg;
    logic [CFG_W-1:0]      max_order_reg;

    logic                  op_reg;
    logic                  op_next;
    logic                  found_reg;
    logic                  found_next;
    logic [RANK_W-1:0]     acc_reg;
    logic [RANK_W-1:0]     acc_next;
    orders_t               orders_reg;
    orders_t               orders_next;
    logic [ORDER_BITS-1:0] budget_reg;
    logic [ORDER_BITS-1:0] budget_next;
    logic [ORDER_BITS-1:0] p_reg;
    logic [ORDER_BITS-1:0] p_next;
    logic [DIM_W-1:0]      k_reg;
    logic [DIM_W-1:0]      k_next;

    logic [DIM_W-1:0]      dm1;
    logic [COUNT_W-1:0]    total;
    logic [DIM_W-1:0]      rem_dims;
    logic [COUNT_W-1:0]    c;
    logic [ORDER_BITS-1:0] o_k;
    logic                  is_last;
    orders_t               in_ord;
    logic [SUM_W-1:0]      in_sum;
    logic                  in_ok;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_dims_reg  <= CFG_W'(2);
            max_order_reg <= CFG_W'(3);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_NUM_DIMS:  num_dims_reg  <= cfg_data;
                CFG_MAX_ORDER: max_order_reg <= cfg_data;
                default:       num_dims_reg  <= num_dims_reg;
            endcase
        end
    end

    // Dimension count less one, with zero taken as one and large values saturated.
    always_comb
    begin
        if (num_dims_reg == '0)
            dm1 = '0;
        else if (num_dims_reg > CFG_W'(MAX_DIMS))
            dm1 = DIM_W'(MAX_DIMS - 1);
        else
            dm1 = DIM_W'(num_dims_reg - CFG_W'(1));
    end

    assign total = binom(CFG_W'(dm1) + CFG_W'(1), max_order_reg);

    // Membership check of an incoming multi-index.
    always_comb
    begin
        in_ord = orders_t'(req.orders_in);
        in_sum = '0;
        in_ok  = 1'b1;
        for (int i = 0; i < MAX_DIMS; i++)
        begin
            if (DIM_W'(i) <= dm1)
                in_sum = in_sum + SUM_W'(in_ord[i]);
            else if (in_ord[i] != '0)
                in_ok = 1'b0;
        end
        if (in_sum > SUM_W'(max_order_reg))
            in_ok = 1'b0;
    end

    assign rem_dims = dm1 - k_reg;
    assign c        = binom(CFG_W'(rem_dims), budget_reg - p_reg);
    assign o_k      = orders_reg[k_reg];
    assign is_last  = (k_reg == dm1);

    always_comb
    begin
        op_next     = op_reg;
        found_next  = found_reg;
        acc_next    = acc_reg;
        orders_next = orders_reg;
        budget_next = budget_reg;
        p_next      = p_reg;
        k_next      = k_reg;
        if (cmd.load)
        begin
            op_next     = req.operation;
            budget_next = max_order_reg;
            p_next      = '0;
            k_next      = '0;
            if (op_t'(req.operation) == OP_TO_INDEX)
            begin
                found_next  = in_ok;
                acc_next    = '0;
                orders_next = in_ord;
            end
            else
            begin
                found_next  = (req.term_index < RANK_W'(total));
                acc_next    = req.term_index;
                orders_next = '0;
            end
        end
        else if (cmd.step && found_reg)
        begin
            if (is_last)
            begin
                // The last dimension takes whatever is left of the rank (to-multi) or adds its order to it (to-index).
                if (op_t'(op_reg) == OP_TO_INDEX)
                    acc_next = acc_reg + RANK_W'(o_k);
                else
                    orders_next[k_reg] = acc_reg[ORDER_BITS-1:0];
            end
            else if (op_t'(op_reg) == OP_TO_INDEX)
            begin
                if (p_reg != o_k)
                begin
                    acc_next = acc_reg + RANK_W'(c);
                    p_next   = p_reg + ORDER_BITS'(1);
                end
                else
                begin
                    budget_next = budget_reg - o_k;
                    k_next      = k_reg + DIM_W'(1);
                    p_next      = '0;
                end
            end
            else
            begin
                // Skip whole blocks of terms while the index lies past them.
                if (p_reg != budget_reg && acc_reg >= RANK_W'(c))
                begin
                    acc_next = acc_reg - RANK_W'(c);
                    p_next   = p_reg + ORDER_BITS'(1);
                end
                else
                begin
                    orders_next[k_reg] = p_reg;
                    budget_next        = budget_reg - p_reg;
                    k_next             = k_reg + DIM_W'(1);
                    p_next             = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            found_reg <= 1'b0;
        else
            found_reg <= found_next;
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        acc_reg    <= acc_next;
        orders_reg <= orders_next;
        budget_reg <= budget_next;
        p_reg      <= p_next;
        k_reg      <= k_next;
    end

    assign status.finish = !found_reg || is_last;

    assign rsp.orders_out = (op_t'(op_reg) == OP_TO_INDEX) ? '0 : ORDERS_W'(orders_reg);
    assign rsp.rank_out   = (op_t'(op_reg) == OP_TO_INDEX) ? acc_reg : '0;
    assign rsp.found      = found_reg;
    assign rsp.term_count = total;

endmodule

@@ design/total_order_multi_index_rank_core.sv @@
`timescale 1ns / 1ps
// Operation: after the accepting edge the core runs a walk and then raises the result strobe;
// a request that is not found ends the walk at once, otherwise the walk makes one step per
// order step (o[k]+1 for each dimension but the last, plus one for the last dimension).
// Throughput: one request at a time; start is taken again in the cycle after the strobe.
// The receiver cannot stall. Reset is asynchronous, active low: num_dims 2, max_order 3.
module total_order_multi_index_rank_core
    import tomir_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  in_item_t         req,
    output logic             done,
    output out_item_t        rsp,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    tomir_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    tomir_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .req       (req),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .status    (status),
        .rsp       (rsp)
    );

endmodule
